### sv/twht_pkg.sv
package twht_pkg;

	typedef enum logic [0:0] {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_SCAN  = 3'b010,
		S_DRAIN = 3'b100
	} state_t;

	typedef struct packed {
		logic signed [12:0] left;
		logic signed [12:0] top;
		logic [11:0]        w;
		logic [11:0]        h;
	} geom_t;

	typedef struct packed {
		logic        used;
		logic        shown;
		logic        mini;
		logic        ontop;
		logic [15:0] z;
	} attr_t;

	typedef struct packed {
		geom_t geom;
		attr_t attr;
	} entry_t;

	typedef struct packed {
		logic clear;
		logic eval;
	} sel_ctl_t;

endpackage

### sv/twht_table.sv
module twht_table import twht_pkg::*; #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned IW    = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [IW-1:0] wr_addr,
	input  geom_t         wr_geom,
	input  attr_t         wr_attr,
	input  logic          rd_en,
	input  logic [IW-1:0] rd_addr,
	output entry_t        rd_entry
);

	geom_t geom_mem [DEPTH];
	attr_t attr_mem [DEPTH];

	logic [DEPTH-1:0] valid_q;
	geom_t            geom_s1;
	attr_t            attr_s1;
	logic             vbit_s1;

	// Slots never written since reset read back as unused.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vbit_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vbit_s1 <= valid_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			geom_mem[wr_addr] <= wr_geom;
			attr_mem[wr_addr] <= wr_attr;
		end
		if (rd_en) begin
			geom_s1 <= geom_mem[rd_addr];
			attr_s1 <= attr_mem[rd_addr];
		end
	end

	always_comb begin
		rd_entry.geom      = geom_s1;
		rd_entry.attr      = attr_s1;
		rd_entry.attr.used = attr_s1.used && vbit_s1;
	end

endmodule

### sv/twht_select.sv
module twht_select import twht_pkg::*; #(
	parameter int unsigned IW = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sel_ctl_t           ctl,
	input  logic [IW-1:0]      idx,
	input  logic signed [12:0] px,
	input  logic signed [12:0] py,
	input  entry_t             entry,
	output logic               held,
	output logic [IW-1:0]      best
);

	logic               held_q;
	logic [IW-1:0]      best_q;
	logic [15:0]        best_z_q;
	logic signed [13:0] right;
	logic signed [13:0] bottom;
	logic signed [13:0] px_w;
	logic signed [13:0] py_w;
	logic               skip;
	logic               in_rect;
	logic               take;

	// Edges are widened by one bit so that left plus width cannot wrap.
	always_comb begin
		px_w    = {px[12], px};
		py_w    = {py[12], py};
		right   = $signed({entry.geom.left[12], entry.geom.left}) + $signed({2'b00, entry.geom.w});
		bottom  = $signed({entry.geom.top[12], entry.geom.top}) + $signed({2'b00, entry.geom.h});
		skip    = !entry.attr.used || !entry.attr.shown || entry.attr.mini;
		in_rect = (px_w >= $signed({entry.geom.left[12], entry.geom.left})) && (px_w < right)
		       && (py_w >= $signed({entry.geom.top[12], entry.geom.top})) && (py_w < bottom);
		take    = ctl.eval && !skip && in_rect
		       && (!held_q || entry.attr.ontop || (best_z_q < entry.attr.z));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= 1'b0;
			best_q   <= '0;
			best_z_q <= '0;
		end else if (ctl.clear) begin
			held_q   <= 1'b0;
			best_q   <= '0;
			best_z_q <= '0;
		end else if (take) begin
			held_q   <= 1'b1;
			best_q   <= idx;
			best_z_q <= entry.attr.z;
		end
	end

	assign held = held_q;
	assign best = best_q;

`ifndef SYNTH
	a_empty_best: assert property (@(posedge clk) disable iff (!arst_n)
		!held_q |-> (best_q == '0))
		else $error("best slot set with nothing held");
`endif

endmodule

### sv/topmost_window_hit_test.sv
// Channel  Handshake     Fields
// -------  ------------  ---------------------------------------------------------
// input    start / busy  opcode slot pos_x pos_y win_width win_height in_use
//                        visible minimized always_on_top z_order
// result   done strobe   hit top_slot
//
// A write word is stored at its accept edge and its result strobes on the next
// cycle; busy stays low, so another word may follow at once.
// A query keeps busy high through the scan and drain states while the single read port
// of the slot table walks one slot per cycle; the result strobes in the cycle
// after, and the next word may be accepted in that same cycle.
// Reset clears the per-slot valid bits at once, so no clearing pass is needed.
// The receiver cannot stall; each result is shown for exactly one cycle.
module topmost_window_hit_test import twht_pkg::*; #(
	parameter int unsigned MAX_WINDOWS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               opcode,
	input  logic [3:0]         slot,
	input  logic signed [12:0] pos_x,
	input  logic signed [12:0] pos_y,
	input  logic [11:0]        win_width,
	input  logic [11:0]        win_height,
	input  logic               in_use,
	input  logic               visible,
	input  logic               minimized,
	input  logic               always_on_top,
	input  logic [15:0]        z_order,
	output logic               done,
	output logic               hit,
	output logic [3:0]         top_slot
);

	localparam int unsigned IW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
	localparam int unsigned SW = IW + 4;
	localparam logic [IW-1:0] LAST = IW'(MAX_WINDOWS - 1);

	state_t             state_q;
	logic [IW-1:0]      idx_q;
	logic [IW-1:0]      idx_s1;
	logic               vld_s1;
	logic               done_q;
	logic               res_query_q;
	logic signed [12:0] px_q;
	logic signed [12:0] py_q;

	logic          accept;
	logic          wr_en;
	logic [SW-1:0] slot_wide;
	logic [IW-1:0] wr_addr;
	geom_t         wr_geom;
	attr_t         wr_attr;
	entry_t        rd_entry;
	sel_ctl_t      sel_ctl;
	logic          held;
	logic [IW-1:0] best;
	logic [SW-1:0] best_wide;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign slot_wide = {{IW{1'b0}}, slot};
	assign wr_addr   = slot_wide[IW-1:0];
	// Writes to slots beyond the table are dropped but still answered.
	assign wr_en     = accept && (opcode == OP_WRITE) && (slot_wide < SW'(MAX_WINDOWS));

	assign wr_geom = '{left: pos_x, top: pos_y, w: win_width, h: win_height};
	assign wr_attr = '{used: in_use, shown: visible, mini: minimized,
	                   ontop: always_on_top, z: z_order};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			idx_s1      <= '0;
			vld_s1      <= 1'b0;
			done_q      <= 1'b0;
			res_query_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= (state_q == S_SCAN);
			idx_s1 <= idx_q;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (opcode == OP_WRITE) begin
							done_q      <= 1'b1;
							res_query_q <= 1'b0;
						end else begin
							state_q <= S_SCAN;
							idx_q   <= '0;
						end
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + IW'(1);
					if (idx_q == LAST) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					// The last slot's data is judged at this edge.
					state_q     <= S_IDLE;
					done_q      <= 1'b1;
					res_query_q <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (opcode == OP_QUERY)) begin
			px_q <= pos_x;
			py_q <= pos_y;
		end
	end

	// Writes are only taken while idle and reads only during a scan, so the
	// two never touch the table in the same cycle.
	twht_table #(
		.DEPTH (MAX_WINDOWS),
		.IW    (IW)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_geom  (wr_geom),
		.wr_attr  (wr_attr),
		.rd_en    (state_q == S_SCAN),
		.rd_addr  (idx_q),
		.rd_entry (rd_entry)
	);

	assign sel_ctl = '{clear: accept && (opcode == OP_QUERY), eval: vld_s1};

	twht_select #(
		.IW (IW)
	) u_select (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sel_ctl),
		.idx    (idx_s1),
		.px     (px_q),
		.py     (py_q),
		.entry  (rd_entry),
		.held   (held),
		.best   (best)
	);

	assign best_wide = {4'b0000, best};
	assign done      = done_q;
	assign hit       = res_query_q && held;
	assign top_slot  = (res_query_q && held) ? best_wide[3:0] : 4'd0;

`ifndef SYNTH
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past((state_q == S_DRAIN) || (start && !busy && opcode == OP_WRITE)))
		else $error("result strobe without a finished word");
	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == OP_WRITE) |=> (done && !hit && top_slot == 4'd0))
		else $error("write word not answered with an empty result");
	a_miss_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (top_slot == 4'd0))
		else $error("miss reported with a nonzero slot");
`endif

endmodule

### verif/window_hit_checker.sv
module window_hit_checker import twht_pkg::*; #(
	parameter int unsigned MAX_WINDOWS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               opcode,
	input  logic [3:0]         slot,
	input  logic signed [12:0] pos_x,
	input  logic signed [12:0] pos_y,
	input  logic [11:0]        win_width,
	input  logic [11:0]        win_height,
	input  logic               in_use,
	input  logic               visible,
	input  logic               minimized,
	input  logic               always_on_top,
	input  logic [15:0]        z_order,
	input  logic               done,
	input  logic               hit,
	input  logic [3:0]         top_slot,
	output int                 mismatches,
	output int                 awaiting
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic       hit;
		logic [3:0] win;
	} hit_answer_t;

	geom_t       geom_tbl [MAX_WINDOWS];
	attr_t       attr_tbl [MAX_WINDOWS];
	hit_answer_t answers_due [$];
	int          fail_count = 0;
	int          due_count = 0;

	assign mismatches = fail_count;
	assign awaiting   = due_count;

	task automatic report_mismatch(string what, logic [3:0] got, logic [3:0] want);
		$display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	// Walks the slots in index order; a later match takes over when nothing is held
	// yet, when it is always-on-top, or when its z is strictly higher.
	function automatic hit_answer_t find_topmost(logic signed [12:0] qx, logic signed [12:0] qy);
		hit_answer_t best;
		logic [15:0] best_z;
		int          left_x;
		int          top_y;
		bit          covers;
		best   = '0;
		best_z = '0;
		for (int i = 0; i < MAX_WINDOWS; i++) begin
			if (!attr_tbl[i].used || !attr_tbl[i].shown || attr_tbl[i].mini)
				continue;
			left_x = int'(signed'(geom_tbl[i].left));
			top_y  = int'(signed'(geom_tbl[i].top));
			covers = int'(qx) >= left_x && int'(qx) < left_x + int'(geom_tbl[i].w) &&
				int'(qy) >= top_y && int'(qy) < top_y + int'(geom_tbl[i].h);
			if (!covers)
				continue;
			if (!best.hit || attr_tbl[i].ontop || best_z < attr_tbl[i].z) begin
				best.hit = 1'b1;
				best.win = i[3:0];
				best_z   = attr_tbl[i].z;
			end
		end
		return best;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		hit_answer_t want;
		if (!arst_n) begin
			foreach (geom_tbl[i]) begin
				geom_tbl[i] = '0;
				attr_tbl[i] = '0;
			end
			answers_due.delete();
			due_count = 0;
		end else begin
			// The result of an earlier word can strobe at the edge that takes a new one,
			// so results are retired before the new word is predicted.
			if (done) begin
				if (answers_due.size() == 0) begin
					$display("%0t ns: result strobe with no word outstanding", $realtime);
					fail_count++;
				end else begin
					want = answers_due.pop_front();
					if (hit !== want.hit)
						report_mismatch("hit", {3'b0, hit}, {3'b0, want.hit});
					if (top_slot !== want.win)
						report_mismatch("top_slot", top_slot, want.win);
				end
			end
			if (start && !busy) begin
				if (opcode == OP_WRITE) begin
					if (slot < MAX_WINDOWS) begin
						geom_tbl[slot] = '{left: pos_x, top: pos_y, w: win_width, h: win_height};
						attr_tbl[slot] = '{used: in_use, shown: visible, mini: minimized,
							ontop: always_on_top, z: z_order};
					end
					answers_due.push_back('0);
				end else begin
					answers_due.push_back(find_topmost(pos_x, pos_y));
				end
			end
			due_count = answers_due.size();
		end
	end

endmodule

### verif/topmost_window_hit_test_tb.sv
module topmost_window_hit_test_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import twht_pkg::*;

	localparam int unsigned MAX_WINDOWS = 16;
	localparam int          RANDOM_WORDS = 700;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               opcode;
	logic [3:0]         slot;
	logic signed [12:0] pos_x;
	logic signed [12:0] pos_y;
	logic [11:0]        win_width;
	logic [11:0]        win_height;
	logic               in_use;
	logic               visible;
	logic               minimized;
	logic               always_on_top;
	logic [15:0]        z_order;
	logic               done;
	logic               hit;
	logic [3:0]         top_slot;
	int                 mismatches;
	int                 awaiting;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	topmost_window_hit_test #(.MAX_WINDOWS(MAX_WINDOWS)) DUT (
		.clk, .arst_n, .start, .busy, .opcode, .slot, .pos_x, .pos_y, .win_width,
		.win_height, .in_use, .visible, .minimized, .always_on_top, .z_order,
		.done, .hit, .top_slot
	);

	window_hit_checker #(.MAX_WINDOWS(MAX_WINDOWS)) checker_i (
		.clk, .arst_n, .start, .busy, .opcode, .slot, .pos_x, .pos_y, .win_width,
		.win_height, .in_use, .visible, .minimized, .always_on_top, .z_order,
		.done, .hit, .top_slot, .mismatches, .awaiting
	);

	// Presents one word and returns at the edge that accepts it; start stays high.
	task automatic send_word(op_t op, logic [3:0] s, logic signed [12:0] x,
		logic signed [12:0] y, logic [11:0] w, logic [11:0] h, logic used,
		logic shown, logic mini, logic ontop, logic [15:0] z);
		opcode        <= op;
		slot          <= s;
		pos_x         <= x;
		pos_y         <= y;
		win_width     <= w;
		win_height    <= h;
		in_use        <= used;
		visible       <= shown;
		minimized     <= mini;
		always_on_top <= ontop;
		z_order       <= z;
		start         <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic write_window(logic [3:0] s, logic signed [12:0] x, logic signed [12:0] y,
		logic [11:0] w, logic [11:0] h, logic used, logic shown, logic mini, logic ontop,
		logic [15:0] z);
		send_word(OP_WRITE, s, x, y, w, h, used, shown, mini, ontop, z);
	endtask

	// The geometry and flag fields of a query carry junk; the block must ignore them.
	task automatic query_point(logic signed [12:0] x, logic signed [12:0] y);
		send_word(OP_QUERY, 4'($urandom), x, y, 12'($urandom), 12'($urandom),
			1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
	endtask

	task automatic random_word();
		logic signed [12:0] x;
		logic signed [12:0] y;
		logic [11:0]        w;
		logic [11:0]        h;
		logic [15:0]        z;
		if ($urandom_range(0, 99) < 40) begin
			if ($urandom_range(0, 4) == 0) begin
				x = 13'($urandom);
				y = 13'($urandom);
				w = 12'($urandom);
				h = 12'($urandom);
			end else begin
				// Most windows pile up in one small area so that queries see overlaps.
				x = 13'($urandom_range(0, 400) - 200);
				y = 13'($urandom_range(0, 400) - 200);
				w = 12'($urandom_range(0, 300));
				h = 12'($urandom_range(0, 300));
			end
			z = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
			write_window(4'($urandom), x, y, w, h, $urandom_range(0, 99) < 85,
				$urandom_range(0, 99) < 85, $urandom_range(0, 99) < 15,
				$urandom_range(0, 99) < 25, z);
		end else if ($urandom_range(0, 99) < 85) begin
			query_point(13'($urandom_range(0, 550) - 250), 13'($urandom_range(0, 550) - 250));
		end else begin
			query_point(13'($urandom), 13'($urandom));
		end
	endtask

	initial begin
		int sent;
		int burst;
		arst_n        = 1'b0;
		start         = 1'b0;
		opcode        = OP_WRITE;
		slot          = '0;
		pos_x         = '0;
		pos_y         = '0;
		win_width     = '0;
		win_height    = '0;
		in_use        = 1'b0;
		visible       = 1'b0;
		minimized     = 1'b0;
		always_on_top = 1'b0;
		z_order       = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		query_point(13'(0), 13'(0));
		// Largest window at the far negative corner; its right and bottom edges are open.
		write_window(4'd0, 13'(-4096), 13'(-4096), 12'd4095, 12'd4095,
			1'b1, 1'b1, 1'b0, 1'b0, 16'd0);
		query_point(13'(-4096), 13'(-4096));
		query_point(13'(-2), 13'(-2));
		query_point(13'(-1), 13'(-1));
		write_window(4'd15, 13'(4095), 13'(4095), 12'd4095, 12'd4095,
			1'b1, 1'b1, 1'b0, 1'b0, 16'hFFFF);
		query_point(13'(4095), 13'(4095));
		write_window(4'd3, 13'(0), 13'(0), 12'd0, 12'd10, 1'b1, 1'b1, 1'b0, 1'b0, 16'd9);
		query_point(13'(0), 13'(5));
		// Equal z keeps the earlier slot.
		write_window(4'd1, 13'(100), 13'(100), 12'd50, 12'd50, 1'b1, 1'b1, 1'b0, 1'b0, 16'd5);
		write_window(4'd2, 13'(100), 13'(100), 12'd50, 12'd50, 1'b1, 1'b1, 1'b0, 1'b0, 16'd5);
		query_point(13'(120), 13'(120));
		// The last always-on-top match wins, yet a later higher z still takes over.
		write_window(4'd4, 13'(100), 13'(100), 12'd50, 12'd50, 1'b1, 1'b1, 1'b0, 1'b1, 16'd0);
		write_window(4'd5, 13'(100), 13'(100), 12'd50, 12'd50, 1'b1, 1'b1, 1'b0, 1'b1, 16'd0);
		query_point(13'(120), 13'(120));
		write_window(4'd6, 13'(100), 13'(100), 12'd50, 12'd50,
			1'b1, 1'b1, 1'b0, 1'b0, 16'hFFFF);
		query_point(13'(149), 13'(149));
		// Hidden, minimized and removed windows are all skipped.
		write_window(4'd7, 13'(-500), 13'(-500), 12'd20, 12'd20,
			1'b1, 1'b0, 1'b0, 1'b1, 16'hFFFF);
		write_window(4'd8, 13'(-500), 13'(-500), 12'd20, 12'd20,
			1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF);
		write_window(4'd9, 13'(-500), 13'(-500), 12'd20, 12'd20,
			1'b0, 1'b1, 1'b0, 1'b1, 16'hFFFF);
		query_point(13'(-490), 13'(-490));
		write_window(4'd9, 13'(-500), 13'(-500), 12'd20, 12'd20,
			1'b1, 1'b1, 1'b0, 1'b0, 16'd1);
		query_point(13'(-490), 13'(-490));

		sent = 0;
		while (sent < RANDOM_WORDS) begin
			burst = $urandom_range(1, 40);
			for (int i = 0; i < burst; i++) begin
				random_word();
				sent++;
			end
			if ($urandom_range(0, 99) < 80) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 12))
					@(posedge clk);
			end
		end
		start <= 1'b0;

		while (awaiting != 0)
			@(posedge clk);
		repeat (MAX_WINDOWS + 4)
			@(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with words still outstanding");
		$display("== FAIL ==");
		$finish;
	end

endmodule

### filelist.f
sv/twht_pkg.sv
sv/twht_table.sv
sv/twht_select.sv
sv/topmost_window_hit_test.sv
verif/window_hit_checker.sv
verif/topmost_window_hit_test_tb.sv
